@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks of the level meter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmsm: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmsm: next-cycle check failed");

`endif

@@ hw/rtl/rmsm_pkg.sv @@
// ----------------------------------------------------------------------------
// RMS meter package
// Fixed widths, state codes and the command and status bundles shared by
// the controller and the datapath.
// ----------------------------------------------------------------------------
package rmsm_pkg;

  // Sample format and capture ring geometry.
  localparam int SAMPLE_BITS = 16;
  localparam int RING_DEPTH  = 512;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  // Width of a mean of squares (largest square is 2**(2*SAMPLE_BITS-2)).
  localparam int MEAN_W      = 2 * SAMPLE_BITS - 1;

  // Item kinds carried on the opcode field.
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_READ   = 1'b1
  } opcode_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ACC,
    ST_DIV,
    ST_ROOT_LOAD,
    ST_ROOT,
    ST_FIN,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic acc;
    logic div_step;
    logic root_init;
    logic root_step;
    logic finish;
    logic load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_read;
    logic is_last;
    logic div_last;
    logic root_last;
    logic out_free;
  } status_t;

endpackage

@@ hw/rtl/rmsm_if.sv @@
// ----------------------------------------------------------------------------
// RMS meter channels
// Valid/ready channels for the input items and the result items.
// ----------------------------------------------------------------------------
interface rmsm_in_if import rmsm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic signed [SAMPLE_BITS-1:0] sample_value;
  logic                          last_in_block;
  logic [RING_AW-1:0]            read_offset;

  modport source (output valid, output opcode, output sample_value,
                  output last_in_block, output read_offset, input ready);
  modport sink   (input valid, input opcode, input sample_value,
                  input last_in_block, input read_offset, output ready);
endinterface

interface rmsm_out_if import rmsm_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] passthrough_sample;
  logic                          level_valid;
  logic [SAMPLE_BITS-1:0]        rms_level;
  logic                          block_overflow;
  logic                          read_valid;
  logic signed [SAMPLE_BITS-1:0] waveform_sample;

  modport source (output valid, output passthrough_sample, output level_valid,
                  output rms_level, output block_overflow, output read_valid,
                  output waveform_sample, input ready);
  modport sink   (input valid, input passthrough_sample, input level_valid,
                  input rms_level, input block_overflow, input read_valid,
                  input waveform_sample, output ready);
endinterface

@@ hw/rtl/rmsm_ctrl.sv @@
// ----------------------------------------------------------------------------
// RMS meter controller
// Sequences capture, ring access, accumulation, the end-of-block divide and
// square root, and the hand-off of each result item.
// ----------------------------------------------------------------------------
module rmsm_ctrl import rmsm_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        state_next = ST_ACC;
      end
      ST_ACC: begin
        if (status.is_last) state_next = ST_DIV;
        else if (status.out_free) state_next = ST_IDLE;
        else state_next = ST_RESP;
      end
      ST_DIV: begin
        if (status.div_last) state_next = ST_ROOT_LOAD;
      end
      ST_ROOT_LOAD: begin
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        if (status.root_last) state_next = ST_FIN;
      end
      ST_FIN: begin
        state_next = ST_RESP;
      end
      ST_RESP: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      ST_ACC: begin
        // Read items leave the accumulator alone; a plain item is sent at once when the output register is free.
        cmd.acc  = !status.is_read;
        cmd.load = !status.is_last && status.out_free;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_ROOT_LOAD: begin
        cmd.root_init = 1'b1;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
      end
      ST_RESP: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ hw/rtl/rmsm_dp.sv @@
// ----------------------------------------------------------------------------
// RMS meter datapath
// Capture ring, square accumulator, shared-step divider and square root,
// held level and the output register.
// ----------------------------------------------------------------------------
module rmsm_dp import rmsm_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic                          cfg_write_data,
  input  logic                          opcode,
  input  logic signed [SAMPLE_BITS-1:0] sample_value,
  input  logic                          last_in_block,
  input  logic [RING_AW-1:0]            read_offset,
  input  cmd_t                          cmd,
  output status_t                       status,
  rmsm_out_if.source                    out_ch
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W  = MEAN_W - 1 + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(MAX_BLOCK);
  localparam int SB = SAMPLE_BITS;

  // Configuration and latched item.
  logic                 meter_enable;
  logic                 op_q;
  logic                 last_q;
  logic signed [SB-1:0] sample_q;
  logic [RING_AW-1:0]   offset_q;
  logic [SB-1:0]        mag_q;
  logic [SB-1:0]        mag_in;
  logic                 is_read;

  // Capture ring and its bookkeeping.
  logic [SB-1:0]        ring [RING_DEPTH];
  logic [RING_AW-1:0]   wp;
  logic [RING_AW:0]     fill;
  logic [RING_AW-1:0]   rd_pos;
  logic [SB-1:0]        rd_data;
  logic                 rd_ok;

  // Accumulator.
  logic [2*SB-1:0]      sq_q;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     sum_acc;
  logic [CNT_W-1:0]     count;
  logic                 sat;
  logic [SB-1:0]        held;
  logic                 lvalid_q;
  logic                 ovf_q;

  // Divider and square root.
  logic [STEP_W-1:0]    step;
  logic [SUM_W-1:0]     quo;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W:0]       rem_sh;
  logic                 div_ge;
  logic [CNT_W-1:0]     div_diff;
  logic [2*SB-1:0]      x;
  logic [SB-1:0]        root;
  logic [SB:0]          rrem;
  logic [SB+2:0]        rrem_sh;
  logic [SB+2:0]        trial;
  logic                 root_ge;
  logic [SB:0]          root_diff;

  assign is_read = (op_q == OP_READ);
  assign mag_in  = sample_value[SB-1] ? $unsigned(-sample_value) : $unsigned(sample_value);
  assign rd_pos  = wp + offset_q;
  assign sum_acc = sum + SUM_W'(sq_q[MEAN_W-1:0]);

  // One restoring divide step: remainder against block count.
  assign rem_sh   = {rem, quo[SUM_W-1]};
  assign div_ge   = rem_sh >= {1'b0, count};
  assign div_diff = CNT_W'(rem_sh - {1'b0, count});

  // One digit of the bitwise square root.
  assign rrem_sh   = {rrem, x[2*SB-1 -: 2]};
  assign trial     = {1'b0, root, 2'b01};
  assign root_ge   = rrem_sh >= trial;
  assign root_diff = (SB+1)'(rrem_sh - trial);

  // Status to the controller.
  assign status.is_read   = is_read;
  assign status.is_last   = !is_read && last_q;
  assign status.div_last  = (step == STEP_W'(SUM_W - 1));
  assign status.root_last = (step == STEP_W'(SB - 1));
  assign status.out_free  = !out_ch.valid || out_ch.ready;

  // Architectural state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      meter_enable <= 1'b0;
      wp           <= '0;
      fill         <= '0;
      sum          <= '0;
      count        <= '0;
      sat          <= 1'b0;
      held         <= '0;
    end else begin
      if (cfg_write_en) meter_enable <= cfg_write_data;
      if (cmd.exec && !is_read) begin
        wp <= wp + 1'b1;
        if (!fill[RING_AW]) fill <= fill + 1'b1;
        if (count < COUNT_MAX) count <= count + 1'b1;
        else sat <= 1'b1;
      end
      if (cmd.acc) sum <= sum_acc;
      if (cmd.finish) begin
        held  <= root;
        sum   <= '0;
        count <= '0;
        sat   <= 1'b0;
      end
    end
  end

  // Item capture, square and end-of-block flags.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= opcode;
      last_q   <= last_in_block;
      sample_q <= sample_value;
      offset_q <= read_offset;
      mag_q    <= mag_in;
      lvalid_q <= 1'b0;
      ovf_q    <= 1'b0;
    end
    if (cmd.exec && !is_read) begin
      sq_q <= (count < COUNT_MAX) ? mag_q * mag_q : '0;
    end
    if (cmd.exec && is_read) begin
      // Entries not yet written since reset read as zero.
      rd_ok <= fill[RING_AW] || ({1'b0, rd_pos} < fill);
    end
    if (cmd.finish) begin
      lvalid_q <= 1'b1;
      ovf_q    <= sat;
    end
  end

  // Capture ring memory.
  always_ff @(posedge clk) begin
    if (cmd.exec && !is_read) ring[wp] <= sample_q;
    if (cmd.exec && is_read) rd_data <= ring[rd_pos];
  end

  // Mean by iterative division, then the root of the mean.
  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      quo  <= sum_acc;
      rem  <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      quo  <= {quo[SUM_W-2:0], div_ge};
      rem  <= div_ge ? div_diff : rem_sh[CNT_W-1:0];
      step <= step + 1'b1;
    end else if (cmd.root_init) begin
      x    <= {1'b0, quo[MEAN_W-1:0]};
      root <= '0;
      rrem <= '0;
      step <= '0;
    end else if (cmd.root_step) begin
      x    <= {x[2*SB-3:0], 2'b00};
      rrem <= root_ge ? root_diff : rrem_sh[SB:0];
      root <= {root[SB-2:0], root_ge};
      step <= step + 1'b1;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_ch.passthrough_sample <= is_read ? '0 : sample_q;
      out_ch.level_valid        <= lvalid_q;
      out_ch.rms_level          <= meter_enable ? held : '0;
      out_ch.block_overflow     <= ovf_q;
      out_ch.read_valid         <= is_read && meter_enable;
      out_ch.waveform_sample    <= (is_read && meter_enable && rd_ok) ? rd_data : '0;
    end
  end

endmodule

@@ hw/rtl/block_rms_meter_with_scope_ring.sv @@
// ----------------------------------------------------------------------------
// RMS level meter with scope ring
// Passes audio samples through, keeps a capture ring for waveform reads and
// reports the RMS level of each finished block.
//
//   channel   dir   handshake        payload
//   in_ch     in    valid / ready    opcode, sample_value, last_in_block,
//                                    read_offset
//   out_ch    out   valid / ready    passthrough_sample, level_valid,
//                                    rms_level, block_overflow, read_valid,
//                                    waveform_sample
//   cfg       in    cfg_write_en     cfg_write_data (meter_enable)
//
// A sample or read item passes through capture, ring access with the
// square, accumulation. A sample that closes a block adds the mean divide,
// one step per sum bit (30 + clog2(MAX_BLOCK+1) steps, 43 by default), then
// a root load, one square-root step per level bit, a hold and the send.
// Reset is synchronous; entries of the ring not yet written read as zero
// through a fill count, so no clearing pass follows reset.
// A result waits in the output register while the next item is taken in.
// ----------------------------------------------------------------------------
module block_rms_meter_with_scope_ring import rmsm_pkg::*; #(
  parameter int MAX_BLOCK = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write_en,
  input  logic       cfg_write_data,
  rmsm_in_if.sink    in_ch,
  rmsm_out_if.source out_ch
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  rmsm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  rmsm_dp #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .opcode         (in_ch.opcode),
    .sample_value   (in_ch.sample_value),
    .last_in_block  (in_ch.last_in_block),
    .read_offset    (in_ch.read_offset),
    .cmd            (cmd),
    .status         (status),
    .out_ch         (out_ch)
  );

endmodule

@@ hw/rtl/rmsm_checker.sv @@
// ----------------------------------------------------------------------------
// RMS meter port checker
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmsm_checker import rmsm_pkg::*; (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] passthrough_sample,
  input logic                          level_valid,
  input logic [SAMPLE_BITS-1:0]        rms_level,
  input logic                          block_overflow,
  input logic                          read_valid,
  input logic signed [SAMPLE_BITS-1:0] waveform_sample
);

  logic [3*SAMPLE_BITS+2:0] out_word;

  assign out_word = {passthrough_sample, level_valid, rms_level, block_overflow,
                     read_valid, waveform_sample};

  // A stalled result stays offered and unchanged.
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_word))

  // One item at a time: the cycle after an accept takes no new item.
  `ASSERT_NEXT(a_in_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)

  // A read result carries no sample and closes no block.
  `ASSERT_IMPLIES(a_read_exclusive, clk, rst, out_valid && read_valid,
                  passthrough_sample == '0 && !level_valid)

  // Overflow is reported only with a finished block.
  `ASSERT_IMPLIES(a_ovf_with_level, clk, rst, out_valid && block_overflow, level_valid)

endmodule

bind block_rms_meter_with_scope_ring rmsm_checker u_rmsm_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .passthrough_sample (out_ch.passthrough_sample),
  .level_valid        (out_ch.level_valid),
  .rms_level          (out_ch.rms_level),
  .block_overflow     (out_ch.block_overflow),
  .read_valid         (out_ch.read_valid),
  .waveform_sample    (out_ch.waveform_sample)
);

@@ tb/sv/tb_block_rms_meter_with_scope_ring.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS level meter with scope ring: self-checking testbench
// Drives sample and waveform read items through the valid/ready channels,
// predicts each result from its own model of the ring, the block
// accumulator and the held level, and checks every result field by field.
// The meter enable is toggled between phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_block_rms_meter_with_scope_ring;
  import rmsm_pkg::*;

  localparam int MAX_BLOCK   = 4096;
  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 100;

  // One result item as the block presents it.
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] pass_smp;
    logic                   lvl_valid;
    logic [SAMPLE_BITS-1:0] level;
    logic                   ovf;
    logic                   rd_valid;
    logic [SAMPLE_BITS-1:0] wave;
  } meter_out_t;

  // Model of the meter state and the queue of results it still owes.
  class meter_scoreboard;
    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    logic [RING_AW-1:0]     wr_ptr;
    logic [42:0]            sq_sum;
    logic [12:0]            blk_count;
    logic [SAMPLE_BITS-1:0] held;
    bit                     sat;
    bit                     enabled;
    meter_out_t             owed_outputs [$];
    int unsigned            errors, checked, n_samples, n_reads, n_blocks, n_ovf, n_live_reads;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ptr    = '0;
      sq_sum    = '0;
      blk_count = '0;
      held      = '0;
      sat       = 1'b0;
      enabled   = 1'b0;
    endfunction

    function void set_enable(bit en);
      enabled = en;
    endfunction

    function int unsigned pending();
      return owed_outputs.size();
    endfunction

    // Integer floor square root of a mean of Q2.30 squares.
    function logic [SAMPLE_BITS-1:0] floor_root(logic [42:0] x);
      logic [SAMPLE_BITS-1:0] r;
      logic [SAMPLE_BITS-1:0] t;
      r = '0;
      for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
        t = r | (16'd1 << b);
        if (43'(t) * 43'(t) <= x) r = t;
      end
      return r;
    endfunction

    // Advance the model by one accepted input item and queue its result.
    function void note_input(opcode_t op, logic [15:0] smp, logic lst, logic [8:0] off);
      meter_out_t         res;
      logic [16:0]        mag;
      logic [42:0]        mean;
      logic [RING_AW-1:0] pos;
      res = '0;
      if (op == OP_SAMPLE) begin
        n_samples++;
        mag = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        res.pass_smp = smp;
        ring[wr_ptr] = smp;
        wr_ptr = wr_ptr + 1'b1;
        // Samples past the maximum block length are captured but not summed.
        if (blk_count < MAX_BLOCK) begin
          sq_sum = sq_sum + 43'(mag) * 43'(mag);
          blk_count = blk_count + 1'b1;
        end else begin
          sat = 1'b1;
        end
        if (lst) begin
          mean = (blk_count != 0) ? sq_sum / 43'(blk_count) : '0;
          held = floor_root(mean);
          res.lvl_valid = 1'b1;
          res.ovf = sat;
          n_blocks++;
          if (sat) n_ovf++;
          sq_sum    = '0;
          blk_count = '0;
          sat       = 1'b0;
        end
      end else begin
        n_reads++;
        // Reads count from the oldest entry, which is the next one written.
        if (enabled) begin
          pos = wr_ptr + off;
          res.rd_valid = 1'b1;
          res.wave = ring[pos];
          n_live_reads++;
        end
      end
      res.level = enabled ? held : '0;
      owed_outputs.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%h, actual 0x%h", $time, name, want, got);
      end
    endfunction

    // Compare one accepted result with the oldest one owed.
    function void check_result(meter_out_t got);
      meter_out_t want;
      checked++;
      if (owed_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual 0x%h", $time, got);
      end else begin
        want = owed_outputs.pop_front();
        compare_field("passthrough_sample", want.pass_smp, got.pass_smp);
        compare_field("level_valid", 16'(want.lvl_valid), 16'(got.lvl_valid));
        compare_field("rms_level", want.level, got.level);
        compare_field("block_overflow", 16'(want.ovf), 16'(got.ovf));
        compare_field("read_valid", 16'(want.rd_valid), 16'(got.rd_valid));
        compare_field("waveform_sample", want.wave, got.wave);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_write_en;
  logic cfg_write_data;
  bit   steady;
  int   stall_cycles;
  meter_scoreboard sb;

  rmsm_in_if  in_ch ();
  rmsm_out_if out_ch ();

  block_rms_meter_with_scope_ring #(.MAX_BLOCK(MAX_BLOCK)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_ch         (in_ch),
    .out_ch        (out_ch)
  );

  // Clock with a 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Result side: random back-pressure, result checks and the stall counter.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result('{pass_smp: out_ch.passthrough_sample,
                          lvl_valid: out_ch.level_valid,
                          level: out_ch.rms_level,
                          ovf: out_ch.block_overflow,
                          rd_valid: out_ch.read_valid,
                          wave: out_ch.waveform_sample});
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      out_ch.ready <= steady || ($urandom_range(0, 99) >= 30);
    end
  end

  // Watchdog: too long without any item moving ends the run.
  initial begin
    @(negedge rst);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Offer one input item, with a random gap first, and wait until it is taken.
  task automatic send_item(opcode_t op, logic [15:0] smp, logic lst, logic [8:0] off);
    while (!steady && $urandom_range(0, 99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.sample_value  <= smp;
    in_ch.last_in_block <= lst;
    in_ch.read_offset   <= off;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(op, smp, lst, off);
  endtask

  // Stop sending and wait until every owed result has arrived.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the meter enable; only called while the block is idle.
  task automatic write_enable(bit en);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= en;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    sb.set_enable(en);
  endtask

  // Mostly random samples, with full scale, zero and one LSB mixed in.
  function automatic logic [15:0] pick_sample();
    if ($urandom_range(0, 99) < 15) begin
      case ($urandom_range(0, 4))
        0:       return 16'h7FFF;
        1:       return 16'h8000;
        2:       return 16'h0000;
        3:       return 16'h0001;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom);
  endfunction

  // Mostly complete blocks with reads interleaved, the rest loose items.
  task automatic random_phase(int unsigned n_items);
    int unsigned sent;
    int unsigned blk_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 80) begin
        blk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
        for (int unsigned k = 1; k <= blk_len; k++) begin
          if ($urandom_range(0, 99) < 20) begin
            send_item(OP_READ, 16'($urandom), 1'($urandom), 9'($urandom));
            sent++;
          end
          send_item(OP_SAMPLE, pick_sample(), k == blk_len, 9'($urandom));
          sent++;
        end
      end else begin
        send_item(opcode_t'($urandom_range(0, 1)), pick_sample(), 1'($urandom), 9'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    sb = new();
    rst            <= 1'b1;
    cfg_write_en   <= 1'b0;
    cfg_write_data <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.opcode        <= OP_SAMPLE;
    in_ch.sample_value  <= '0;
    in_ch.last_in_block <= 1'b0;
    in_ch.read_offset   <= '0;
    steady = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reads of the empty ring, full-scale and one-LSB blocks.
    write_enable(1'b1);
    send_item(OP_READ, 16'h0000, 1'b0, 9'd0);
    send_item(OP_READ, 16'hFFFF, 1'b1, 9'd511);
    send_item(OP_SAMPLE, 16'h7FFF, 1'b1, 9'd0);
    send_item(OP_SAMPLE, 16'h8000, 1'b1, 9'd511);
    send_item(OP_SAMPLE, 16'h0000, 1'b1, 9'd0);
    send_item(OP_SAMPLE, 16'h0001, 1'b0, 9'd0);
    send_item(OP_SAMPLE, 16'hFFFF, 1'b1, 9'd0);
    // A read in the middle of a block carrying a last mark does not close the block.
    send_item(OP_SAMPLE, 16'sd12345, 1'b0, 9'd0);
    send_item(OP_SAMPLE, -16'sd20000, 1'b0, 9'd0);
    send_item(OP_READ, 16'h1234, 1'b1, 9'd0);
    send_item(OP_SAMPLE, 16'sd300, 1'b1, 9'd0);
    // Offsets that wrap around the ring, newest entry and unwritten ones.
    send_item(OP_READ, 16'h0000, 1'b0, 9'd511);
    send_item(OP_READ, 16'h0000, 1'b0, 9'd510);
    send_item(OP_READ, 16'h0000, 1'b0, 9'd256);
    send_item(OP_READ, 16'h0000, 1'b0, 9'd1);
    drain();

    // Directed, meter disabled: blocks still finish, reads give zero.
    write_enable(1'b0);
    send_item(OP_SAMPLE, 16'h8000, 1'b1, 9'd0);
    send_item(OP_READ, 16'h0000, 1'b0, 9'd3);
    send_item(OP_SAMPLE, 16'sd5, 1'b0, 9'd0);
    drain();
    write_enable(1'b1);
    send_item(OP_READ, 16'h0000, 1'b0, 9'd511);
    send_item(OP_SAMPLE, 16'sd7, 1'b1, 9'd0);
    drain();

    // Random phases across both enable settings.
    write_enable(1'b0);
    random_phase(250);
    drain();
    write_enable(1'b1);
    random_phase(200);
    drain();
    random_phase(200);
    drain();

    // Back to back with no gaps on either side.
    steady = 1'b1;
    random_phase(300);
    drain();
    steady = 1'b0;

    write_enable(1'b0);
    random_phase(200);
    drain();

    write_enable(1'b1);
    random_phase(300);
    drain();

    // Let any stray result show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d samples, %0d reads (%0d while enabled)",
             sb.checked, sb.n_samples, sb.n_reads, sb.n_live_reads);
    $display("Finished %0d blocks, %0d of them past the maximum length",
             sb.n_blocks, sb.n_ovf);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
